>>> rtl/core/gmii_rx_frame_deframer_macros.svh
// assertion macros for the gmii receive deframer
`ifndef GMII_RX_FRAME_DEFRAMER_MACROS_SVH
`define GMII_RX_FRAME_DEFRAMER_MACROS_SVH

// clocked assertion, ignored while reset is high
`define GRFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define GRFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/grfd_pkg.sv
// shared types, constants and crc function for the gmii receive deframer
`default_nettype none

package grfd_pkg;

   localparam int HOLD_DEPTH = 5;
   localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);

   localparam logic [7:0]  SOF_BYTE    = 8'hD5;
   localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_RESIDUE = 32'hDEBB_20E3;
   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

   typedef struct packed {
      logic push;
      logic clear;
   } grfd_ctl_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/grfd_crc.sv
// running ethernet crc-32 over frame bytes with residue check
`default_nettype none

module grfd_crc (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire grfd_pkg::grfd_ctl_type ctl,
   input  wire logic [7:0]            data,
   output logic                       residue_ok
);
   import grfd_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctl.clear) begin
         crc_in = CRC_PRESET;
      end else if (ctl.push) begin
         crc_in = crc_byte(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_PRESET;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign residue_ok = (crc_ff == CRC_RESIDUE);

endmodule

`default_nettype wire

>>> rtl/core/grfd_hold.sv
// five-byte hold line that keeps the fcs bytes back
`default_nettype none

module grfd_hold (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire grfd_pkg::grfd_ctl_type ctl,
   input  wire logic [7:0]            data,
   output logic                       full,
   output logic [7:0]                 oldest
);
   import grfd_pkg::*;

   logic [7:0]            bytes_ff [HOLD_DEPTH];
   logic [7:0]            bytes_in [HOLD_DEPTH];
   logic [HOLD_CNT_W-1:0] count_ff;
   logic [HOLD_CNT_W-1:0] count_in;

   assign full   = (count_ff == HOLD_CNT_W'(HOLD_DEPTH));
   assign oldest = bytes_ff[0];

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         bytes_in[i] = bytes_ff[i];
      end
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.push) begin
         if (full) begin
            for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
               bytes_in[i] = bytes_ff[i + 1];
            end
            bytes_in[HOLD_DEPTH - 1] = data;
         end else begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               if (count_ff == HOLD_CNT_W'(i)) begin
                  bytes_in[i] = data;
               end
            end
            count_in = count_ff + HOLD_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         bytes_ff[i] <= bytes_in[i];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/gmii_rx_frame_deframer.sv
// gmii receive deframer: preamble skip, fcs strip and crc-32 check
// a result beat is valid in the cycle after the input beat that causes it
// throughput: one input beat per cycle while req_ready is high, with the crc updated per byte
// req_ready stays high while the output register is empty or being drained
// synchronous reset returns to idle with the hold line empty and crc preset
`default_nettype none

module gmii_rx_frame_deframer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_data_valid,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_frame_last,
   output logic            rsp_frame_error
);
   import grfd_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PREAMBLE,
      PH_FRAME
   } phase_type;

   phase_type    phase_ff;
   phase_type    phase_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [7:0]   out_byte_ff;
   logic [7:0]   out_byte_in;
   logic         last_ff;
   logic         last_in;
   logic         error_ff;
   logic         error_in;
   logic         accept;
   logic         emit;
   logic         hold_full;
   logic [7:0]   hold_oldest;
   logic         residue_ok;
   grfd_ctl_type ctl;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in    = phase_ff;
      ctl         = '0;
      emit        = 1'b0;
      out_byte_in = out_byte_ff;
      last_in     = last_ff;
      error_in    = error_ff;
      if (accept) begin
         case (phase_ff)
            PH_FRAME: begin
               if (req_data_valid) begin
                  ctl.push = 1'b1;
                  if (hold_full) begin
                     emit        = 1'b1;
                     out_byte_in = hold_oldest;
                     last_in     = 1'b0;
                     error_in    = 1'b0;
                  end
               end else begin
                  emit        = 1'b1;
                  ctl.clear   = 1'b1;
                  phase_in    = PH_IDLE;
                  last_in     = 1'b1;
                  out_byte_in = hold_full ? hold_oldest : 8'd0;
                  error_in    = hold_full ? !residue_ok : 1'b1;
               end
            end
            default: begin
               if (!req_data_valid) begin
                  phase_in = PH_IDLE;
               end else if (req_rx_byte == SOF_BYTE) begin
                  phase_in  = PH_FRAME;
                  ctl.clear = 1'b1;
               end else begin
                  phase_in = PH_PREAMBLE;
               end
            end
         endcase
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      error_ff    <= error_in;
   end

   grfd_crc u_crc (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .data       (req_rx_byte),
      .residue_ok (residue_ok)
   );

   grfd_hold u_hold (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .data   (req_rx_byte),
      .full   (hold_full),
      .oldest (hold_oldest)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_frame_last  = last_ff;
   assign rsp_frame_error = error_ff;

endmodule

`default_nettype wire

>>> rtl/core/grfd_checker.sv
// port-level assertions for the gmii receive deframer and their bind
`default_nettype none

`include "gmii_rx_frame_deframer_macros.svh"

module grfd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_data_valid,
   input wire logic [7:0] req_rx_byte,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_frame_last,
   input wire logic       rsp_frame_error
);

   `GRFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_frame_last) && $stable(rsp_frame_error), "stalled result beat changed")
   `GRFD_ASSERT(a_err_last, clock, reset, rsp_valid && rsp_frame_error |-> rsp_frame_last, "error flag on a beat that is not last")
   `GRFD_ASSERT(a_ready_empty, clock, reset, !rsp_valid |-> req_ready, "input stalled while output empty")
   `GRFD_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result beat right after reset")

endmodule

bind gmii_rx_frame_deframer grfd_checker u_grfd_checker (.*);

`default_nettype wire
